### rtl/mfq_pkg.sv
// Shared types and codes for the media frame queue.
// No dependencies; imported by the top level, the scoreboard and the testbench.
package mfq_pkg;

  typedef enum logic [2:0] {
    CMD_DELIVER = 3'd0,
    CMD_RECEIVE = 3'd1,
    CMD_PREVIEW = 3'd2,
    CMD_STORE   = 3'd3,
    CMD_DROP    = 3'd4,
    CMD_FLUSH   = 3'd5
  } cmd_e;

  localparam logic [2:0] KIND_AUDIO = 3'd0;
  localparam logic [2:0] KIND_VIDEO = 3'd1;
  localparam logic [2:0] KIND_EOS   = 3'd2;
  localparam logic [2:0] KIND_FLUSH = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd5;

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  kind;
    logic        key;
    logic [15:0] duration;
    logic [15:0] samples;
  } frame_t;

endpackage

### rtl/media_frame_queue_with_drop.sv
// Top level of the media frame queue with push-back slot and head drop.
// Depends on mfq_pkg and mfq_ram.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o | command_i and frame fields
//   out     | output    | out_valid_o/out_stall_i | accepted_o, frame, totals
//
// Every command passes through an accept state, in which the head entry is read
// from the descriptor RAM, and then an execute state. A drop stays in the execute
// state while it removes entries, since each removal needs the next head read from
// the RAM. The descriptor RAM has no reset; only written entries are read.
// A finished result sits in an output register; the last execute step waits while
// that register is full and stalled, and a new word is taken once the block is idle.
module media_frame_queue_with_drop #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] frame_tag_i,
  input  logic [2:0]  frame_kind_i,
  input  logic        frame_key_i,
  input  logic [15:0] frame_duration_i,
  input  logic [15:0] frame_samples_i,
  input  logic        store_empty_i,
  input  logic [31:0] drop_target_i,
  input  logic        flush_leave_clear_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        frame_valid_o,
  output logic [15:0] out_tag_o,
  output logic [2:0]  out_kind_o,
  output logic        out_key_o,
  output logic [15:0] out_duration_o,
  output logic [6:0]  queue_count_o,
  output logic [31:0] audio_duration_total_o,
  output logic [31:0] audio_sample_total_o,
  output logic [6:0]  video_count_o,
  output logic [6:0]  key_count_o,
  output logic        has_control_o
);
  import mfq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $clog2(QUEUE_DEPTH + 2);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  frame_t          frame_q, frame_d;
  logic            store_empty_q, store_empty_d;
  logic [31:0]     target_q, target_d;
  logic            leave_clear_q, leave_clear_d;
  logic            dropped_video_q, dropped_video_d;

  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic            slot_valid_q, slot_valid_d;
  frame_t          slot_q, slot_d;
  logic [EW-1:0]   end_q, end_d;
  logic [31:0]     dur_sum_q, dur_sum_d;
  logic [31:0]     smp_sum_q, smp_sum_d;
  logic [CW-1:0]   video_q, video_d;
  logic [CW-1:0]   key_q, key_d;

  // Result register.
  logic            out_valid_q;
  logic            acc_q;
  logic            fv_q;
  frame_t          rframe_q;
  logic [6:0]      qcount_q;
  logic [31:0]     rdur_q, rsmp_q;
  logic [6:0]      rvideo_q, rkey_q;
  logic            rctrl_q;

  logic            finish, acc, fv, do_pop, wr_en;
  frame_t          rframe;
  frame_t          head_w;
  logic [AW-1:0]   tail;
  logic [AW:0]     tail_sum;
  logic [CW:0]     qsum;
  logic            head_key, audio_ok, stop;

  mfq_ram #(
    .WIDTH($bits(frame_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (tail),
    .wr_data_i (frame_q),
    .rd_en_i   (1'b1),
    .rd_addr_i (head_d),
    .rd_data_o (head_w)
  );

  // Write position is head plus count, wrapped at the queue depth.
  always_comb begin
    tail_sum = {1'b0, head_q} + (AW + 1)'(count_q);
    if (tail_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (AW + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  assign head_key = (head_w.kind == KIND_VIDEO) && head_w.key;
  assign audio_ok = dur_sum_q <= target_q;

  // Drop stops on an empty queue, on markers, when the audio total fits the target, or when the key-frame rules say so.
  always_comb begin
    stop = 1'b0;
    if (count_q == '0 || head_w.kind == KIND_FLUSH || head_w.kind == KIND_EOS) begin
      stop = 1'b1;
    end else if (video_q != '0) begin
      if (audio_ok && !dropped_video_q) begin
        stop = 1'b1;
      end else if (audio_ok && dropped_video_q && head_key) begin
        stop = 1'b1;
      end else if (head_w.kind == KIND_VIDEO) begin
        if (head_w.key) begin
          stop = key_q <= CW'(1);
        end else begin
          stop = key_q == '0;
        end
      end
    end else begin
      stop = audio_ok;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_d           = cmd_q;
    frame_d         = frame_q;
    store_empty_d   = store_empty_q;
    target_d        = target_q;
    leave_clear_d   = leave_clear_q;
    dropped_video_d = dropped_video_q;
    head_d          = head_q;
    count_d         = count_q;
    slot_valid_d    = slot_valid_q;
    slot_d          = slot_q;
    end_d           = end_q;
    dur_sum_d       = dur_sum_q;
    smp_sum_d       = smp_sum_q;
    video_d         = video_q;
    key_d           = key_q;
    finish          = 1'b0;
    acc             = 1'b0;
    fv              = 1'b0;
    rframe          = '0;
    do_pop          = 1'b0;
    wr_en           = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d           = cmd_e'(command_i);
          frame_d         = '{tag: frame_tag_i, kind: frame_kind_i, key: frame_key_i,
                              duration: frame_duration_i, samples: frame_samples_i};
          store_empty_d   = store_empty_i;
          target_d        = drop_target_i;
          leave_clear_d   = flush_leave_clear_i;
          dropped_video_d = 1'b0;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          finish = 1'b1;
          case (cmd_q)
            CMD_DELIVER: begin
              if (count_q < CW'(QUEUE_DEPTH)) begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
                if (frame_q.kind == KIND_EOS) end_d = end_q + EW'(1);
                if (frame_q.kind == KIND_AUDIO) begin
                  dur_sum_d = dur_sum_q + 32'(frame_q.duration);
                  smp_sum_d = smp_sum_q + 32'(frame_q.samples);
                end else if (frame_q.kind == KIND_VIDEO) begin
                  video_d = video_q + CW'(1);
                  if (frame_q.key) key_d = key_q + CW'(1);
                end
                acc = 1'b1;
              end
            end
            CMD_RECEIVE, CMD_PREVIEW: begin
              if (slot_valid_q) begin
                rframe = slot_q;
                fv     = 1'b1;
                if (cmd_q == CMD_RECEIVE) begin
                  slot_valid_d = 1'b0;
                  slot_d       = '0;
                end
              end else if (count_q != '0) begin
                rframe = head_w;
                fv     = 1'b1;
                do_pop = cmd_q == CMD_RECEIVE;
              end
              if (fv && cmd_q == CMD_RECEIVE && rframe.kind == KIND_EOS && end_q != '0) begin
                end_d = end_q - EW'(1);
              end
              acc = fv;
            end
            CMD_STORE: begin
              if (!(slot_valid_q && slot_q.kind == KIND_CLEAR)) begin
                if (slot_valid_q && slot_q.kind == KIND_EOS && end_q != '0) begin
                  end_d = end_q - EW'(1);
                end
                if (store_empty_q) begin
                  slot_valid_d = 1'b0;
                  slot_d       = '0;
                end else begin
                  if (frame_q.kind == KIND_EOS) end_d = end_d + EW'(1);
                  slot_valid_d = 1'b1;
                  slot_d       = frame_q;
                end
                acc = 1'b1;
              end
            end
            CMD_DROP: begin
              if (target_q != '0) begin
                acc = 1'b1;
                if (!stop) begin
                  // Remove the head; the next head is read from the RAM and examined in the execute state.
                  finish = 1'b0;
                  do_pop = 1'b1;
                  if (head_w.kind == KIND_VIDEO && video_q != '0) dropped_video_d = 1'b1;
                end
              end
            end
            CMD_FLUSH: begin
              head_d       = '0;
              count_d      = '0;
              end_d        = '0;
              dur_sum_d    = '0;
              smp_sum_d    = '0;
              video_d      = '0;
              key_d        = '0;
              slot_valid_d = leave_clear_q;
              slot_d       = '0;
              if (leave_clear_q) slot_d.kind = KIND_CLEAR;
              acc = 1'b1;
            end
            default: begin
              acc = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_pop) begin
      head_d  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
      count_d = count_q - CW'(1);
      if (head_w.kind == KIND_AUDIO) begin
        dur_sum_d = dur_sum_q - 32'(head_w.duration);
        smp_sum_d = smp_sum_q - 32'(head_w.samples);
      end else if (head_w.kind == KIND_VIDEO) begin
        if (video_q != '0) video_d = video_q - CW'(1);
        if (head_w.key && key_q != '0) key_d = key_q - CW'(1);
      end
    end

    if (finish) state_d = ST_IDLE;
  end

  assign qsum = (CW + 1)'(count_d) + (CW + 1)'(slot_valid_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cmd_q           <= CMD_DELIVER;
      frame_q         <= '0;
      store_empty_q   <= 1'b0;
      target_q        <= '0;
      leave_clear_q   <= 1'b0;
      dropped_video_q <= 1'b0;
      head_q          <= '0;
      count_q         <= '0;
      slot_valid_q    <= 1'b0;
      slot_q          <= '0;
      end_q           <= '0;
      dur_sum_q       <= '0;
      smp_sum_q       <= '0;
      video_q         <= '0;
      key_q           <= '0;
      out_valid_q     <= 1'b0;
      acc_q           <= 1'b0;
      fv_q            <= 1'b0;
      rframe_q        <= '0;
      qcount_q        <= '0;
      rdur_q          <= '0;
      rsmp_q          <= '0;
      rvideo_q        <= '0;
      rkey_q          <= '0;
      rctrl_q         <= 1'b0;
    end else begin
      state_q         <= state_d;
      cmd_q           <= cmd_d;
      frame_q         <= frame_d;
      store_empty_q   <= store_empty_d;
      target_q        <= target_d;
      leave_clear_q   <= leave_clear_d;
      dropped_video_q <= dropped_video_d;
      head_q          <= head_d;
      count_q         <= count_d;
      slot_valid_q    <= slot_valid_d;
      slot_q          <= slot_d;
      end_q           <= end_d;
      dur_sum_q       <= dur_sum_d;
      smp_sum_q       <= smp_sum_d;
      video_q         <= video_d;
      key_q           <= key_d;
      if (finish) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc;
        fv_q        <= fv;
        rframe_q    <= rframe;
        qcount_q    <= 7'(qsum);
        rdur_q      <= dur_sum_d;
        rsmp_q      <= smp_sum_d;
        rvideo_q    <= 7'(video_d);
        rkey_q      <= 7'(key_d);
        rctrl_q     <= (slot_valid_d && slot_d.kind == KIND_CLEAR) || end_d != '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o             = state_q != ST_IDLE;
  assign out_valid_o            = out_valid_q;
  assign accepted_o             = acc_q;
  assign frame_valid_o          = fv_q;
  assign out_tag_o              = rframe_q.tag;
  assign out_kind_o             = rframe_q.kind;
  assign out_key_o              = rframe_q.key;
  assign out_duration_o         = rframe_q.duration;
  assign queue_count_o          = qcount_q;
  assign audio_duration_total_o = rdur_q;
  assign audio_sample_total_o   = rsmp_q;
  assign video_count_o          = rvideo_q;
  assign key_count_o            = rkey_q;
  assign has_control_o          = rctrl_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH)) else $error("entry count exceeds depth");

  a_key_le_video: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q <= video_q) else $error("key frame count exceeds video count");

  a_video_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    video_q <= count_q) else $error("video count exceeds entry count");

endmodule

### rtl/mfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### dv/mfq_scoreboard.sv
// Scoreboard class for the media frame queue: a behavioral queue predictor and
// a store of expected result words. Depends on mfq_pkg.
package mfq_scoreboard_pkg;
  import mfq_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic        frame_valid;
    logic [15:0] tag;
    logic [2:0]  kind;
    logic        key;
    logic [15:0] duration;
    logic [6:0]  queue_count;
    logic [31:0] dur_total;
    logic [31:0] smp_total;
    logic [6:0]  video_count;
    logic [6:0]  key_count;
    logic        has_control;
  } result_t;

  class mfq_scoreboard;
    localparam int DEPTH = 64;
    frame_t      ring[DEPTH];
    int unsigned head, fill, eos_cnt, vid_sum, key_sum;
    logic [31:0] dur_sum, smp_sum;
    bit          slot_full;
    frame_t      slot;
    result_t     pending[$];
    int          mismatches;

    function new();
      wipe();
      mismatches = 0;
    endfunction

    function void wipe();
      head = 0; fill = 0; eos_cnt = 0; vid_sum = 0; key_sum = 0;
      dur_sum = 0; smp_sum = 0; slot_full = 0; slot = '0;
    endfunction

    function void tally(frame_t f, bit add);
      if (f.kind == KIND_AUDIO) begin
        dur_sum = add ? dur_sum + f.duration : dur_sum - f.duration;
        smp_sum = add ? smp_sum + f.samples : smp_sum - f.samples;
      end else if (f.kind == KIND_VIDEO) begin
        if (add) begin
          vid_sum++;
          if (f.key) key_sum++;
        end else begin
          if (vid_sum > 0) vid_sum--;
          if (f.key && key_sum > 0) key_sum--;
        end
      end
    endfunction

    function frame_t take_head();
      frame_t f;
      f = ring[head];
      head = (head + 1) % DEPTH;
      fill--;
      tally(f, 0);
      return f;
    endfunction

    function void trim_head(logic [31:0] target);
      frame_t h;
      bit video_gone, fits;
      video_gone = 0;
      while (fill > 0) begin
        h = ring[head];
        fits = dur_sum <= target;
        if (h.kind == KIND_FLUSH || h.kind == KIND_EOS) break;
        if (vid_sum > 0) begin
          if (fits && !video_gone) break;
          if (fits && h.kind == KIND_VIDEO && h.key) break;
          if (h.kind == KIND_VIDEO) begin
            if (h.key ? key_sum <= 1 : key_sum == 0) break;
            video_gone = 1;
          end
        end else if (fits) break;
        void'(take_head());
      end
    endfunction

    // Apply one accepted command word and queue the result it must produce.
    function void note_command(cmd_e cmd, frame_t f, bit store_empty,
                               logic [31:0] target, bit leave_clear);
      result_t r;
      frame_t  got;
      r = '0; got = '0;
      case (cmd)
        CMD_DELIVER: if (fill < DEPTH) begin
          ring[(head + fill) % DEPTH] = f;
          fill++;
          if (f.kind == KIND_EOS) eos_cnt++;
          tally(f, 1);
          r.accepted = 1;
        end
        CMD_RECEIVE, CMD_PREVIEW: begin
          if (slot_full) begin
            got = slot; r.frame_valid = 1;
            if (cmd == CMD_RECEIVE) begin
              slot_full = 0; slot = '0;
            end
          end else if (fill > 0) begin
            got = (cmd == CMD_RECEIVE) ? take_head() : ring[head];
            r.frame_valid = 1;
          end
          if (cmd == CMD_RECEIVE && r.frame_valid && got.kind == KIND_EOS && eos_cnt > 0)
            eos_cnt--;
          r.accepted = r.frame_valid;
        end
        CMD_STORE: if (!(slot_full && slot.kind == KIND_CLEAR)) begin
          if (slot_full && slot.kind == KIND_EOS && eos_cnt > 0) eos_cnt--;
          if (store_empty) begin
            slot_full = 0; slot = '0;
          end else begin
            if (f.kind == KIND_EOS) eos_cnt++;
            slot_full = 1; slot = f;
          end
          r.accepted = 1;
        end
        CMD_DROP: if (target != 0) begin
          trim_head(target);
          r.accepted = 1;
        end
        CMD_FLUSH: begin
          wipe();
          if (leave_clear) begin
            slot_full = 1; slot.kind = KIND_CLEAR;
          end
          r.accepted = 1;
        end
        default: ;
      endcase
      if (r.frame_valid) begin
        r.tag = got.tag; r.kind = got.kind; r.key = got.key; r.duration = got.duration;
      end
      r.queue_count = 7'(fill + slot_full);
      r.dur_total = dur_sum;
      r.smp_total = smp_sum;
      r.video_count = 7'(vid_sum);
      r.key_count = 7'(key_sum);
      r.has_control = (slot_full && slot.kind == KIND_CLEAR) || eos_cnt > 0;
      pending = {pending, r};
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", act);
        return;
      end
      exp = pending.pop_front();
      if (act !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch exp %h act %h", exp, act);
      end
    endfunction
  endclass
endpackage

### dv/tb_media_frame_queue_with_drop.sv
// Testbench for media_frame_queue_with_drop: directed and random command words
// checked against a scoreboard. Depends on mfq_pkg and mfq_scoreboard_pkg.
module tb_media_frame_queue_with_drop;
  timeunit 1ns;
  timeprecision 1ps;
  import mfq_pkg::*;
  import mfq_scoreboard_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [15:0] frame_tag_i = '0;
  logic [2:0]  frame_kind_i = '0;
  logic        frame_key_i = 0;
  logic [15:0] frame_duration_i = '0;
  logic [15:0] frame_samples_i = '0;
  logic        store_empty_i = 0;
  logic [31:0] drop_target_i = '0;
  logic        flush_leave_clear_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        accepted_o, frame_valid_o, out_key_o, has_control_o;
  logic [15:0] out_tag_o, out_duration_o;
  logic [2:0]  out_kind_o;
  logic [6:0]  queue_count_o, video_count_o, key_count_o;
  logic [31:0] audio_duration_total_o, audio_sample_total_o;

  media_frame_queue_with_drop DUT (.*);

  mfq_scoreboard frame_board = new();
  // When set, the receiver holds off entirely so the block backs up.
  bit      hold_off = 0;
  longint  cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a healthy run takes far fewer cycles than this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Results are sampled at the edge where the handshake completes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      frame_board.check_result({accepted_o, frame_valid_o, out_tag_o, out_kind_o, out_key_o,
                                out_duration_o, queue_count_o, audio_duration_total_o,
                                audio_sample_total_o, video_count_o, key_count_o,
                                has_control_o});
  end

  // The receiver stalls on its own random duty pattern, which is picked anew at intervals
  // and includes stretches with no stall at all.
  initial begin
    int duty;
    duty = 0;
    forever begin
      @(posedge clk_i);
      if (cycle_count % 300 == 0) duty = $urandom_range(0, 3) * 25;
      out_stall_i <= hold_off || ($urandom_range(0, 99) < duty);
    end
  end

  // Offer one word and hold it steady until the block takes it.
  task automatic send_word(cmd_e cmd, frame_t f, bit store_empty, logic [31:0] target,
                           bit leave_clear);
    command_i <= cmd;
    frame_tag_i <= f.tag;
    frame_kind_i <= f.kind;
    frame_key_i <= f.key;
    frame_duration_i <= f.duration;
    frame_samples_i <= f.samples;
    store_empty_i <= store_empty;
    drop_target_i <= target;
    flush_leave_clear_i <= leave_clear;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    frame_board.note_command(cmd, f, store_empty, target, leave_clear);
  endtask

  function automatic frame_t make_frame(logic [2:0] kind);
    frame_t f;
    f.tag = 16'($urandom);
    f.kind = kind;
    f.key = 1'($urandom);
    f.duration = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    f.samples = 16'($urandom);
    return f;
  endfunction

  // Mostly audio and video, with occasional markers and the unused kinds.
  function automatic logic [2:0] pick_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return KIND_AUDIO;
    if (p < 85) return KIND_VIDEO;
    return 3'($urandom_range(2, 7));
  endfunction

  task automatic random_word(int deliver_bias);
    int p;
    cmd_e cmd;
    logic [31:0] target;
    p = $urandom_range(0, 99);
    if (p < deliver_bias) cmd = CMD_DELIVER;
    else if (p < deliver_bias + 15) cmd = CMD_RECEIVE;
    else if (p < deliver_bias + 22) cmd = CMD_PREVIEW;
    else if (p < deliver_bias + 29) cmd = CMD_STORE;
    else if (p < 97) cmd = CMD_DROP;
    else if (p < 99) cmd = CMD_FLUSH;
    else cmd = cmd_e'(3'($urandom_range(6, 7)));
    target = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000);
    send_word(cmd, make_frame(pick_kind()), $urandom_range(0, 3) == 0, target,
              1'($urandom));
  endtask

  task automatic drain_wait();
    in_valid_i <= 0;
    while (frame_board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    frame_t f;
    int burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty receive and preview, extreme fields, markers, refused
    // store over a clear marker, zero drop target, unused command codes.
    send_word(CMD_RECEIVE, '0, 0, 0, 0);
    send_word(CMD_PREVIEW, '0, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'hFFFF, KIND_AUDIO, 1'b1, 16'hFFFF, 16'hFFFF}, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'h0, KIND_VIDEO, 1'b1, 16'h0, 16'h0}, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'h1234, KIND_VIDEO, 1'b0, 16'h10, 16'h5}, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'h55, KIND_AUDIO, 1'b0, 16'h8000, 16'h1}, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'h7, 3'd7, 1'b1, 16'h3, 16'h3}, 0, 0, 0);
    send_word(CMD_DELIVER, '{16'h9, KIND_EOS, 1'b0, 16'h0, 16'h0}, 0, 0, 0);
    send_word(CMD_PREVIEW, '0, 0, 0, 0);
    send_word(CMD_DROP, '0, 0, 32'd0, 0);
    send_word(CMD_DROP, '0, 0, 32'd1, 0);
    send_word(CMD_DROP, '0, 0, 32'hFFFF_FFFF, 0);
    send_word(CMD_STORE, '{16'hABCD, KIND_EOS, 1'b1, 16'h1, 16'h1}, 0, 0, 0);
    send_word(CMD_STORE, '{16'h1, KIND_FLUSH, 1'b0, 16'h1, 16'h1}, 0, 0, 0);
    send_word(CMD_STORE, '0, 1, 0, 0);
    send_word(CMD_FLUSH, '0, 0, 0, 1);
    send_word(CMD_STORE, '{16'h2, KIND_AUDIO, 1'b0, 16'h2, 16'h2}, 0, 0, 0);
    send_word(CMD_PREVIEW, '0, 0, 0, 0);
    send_word(CMD_RECEIVE, '0, 0, 0, 0);
    send_word(cmd_e'(3'd6), '0, 0, 0, 0);
    send_word(cmd_e'(3'd7), '0, 0, 0, 0);
    send_word(CMD_FLUSH, '0, 0, 0, 0);

    // Hold the receiver off while the sender keeps delivering, so the block stalls its
    // input; the queue then fills to its depth and further delivers are refused.
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (70) send_word(CMD_DELIVER, make_frame(pick_kind()), 0, 0, 0);
    join
    // Pause until every expected word has come back.
    drain_wait();

    // Random bursts with random gaps; the deliver bias moves with the phase so
    // the queue swings between nearly empty and full.
    for (int i = 0; i < 1500; i += burst) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) random_word(((i / 300) % 2 == 0) ? 55 : 25);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    drain_wait();

    if (frame_board.mismatches == 0 && frame_board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

### sim.f
rtl/mfq_pkg.sv
rtl/mfq_ram.sv
rtl/media_frame_queue_with_drop.sv
dv/mfq_scoreboard.sv
dv/tb_media_frame_queue_with_drop.sv
